[hdl/fwt_pkg.sv]
package fwt_pkg;

  localparam int DEF_TABLE_DEPTH     = 64;
  localparam int DEF_ADDRESS_WIDTH   = 64;
  localparam int DEF_THREAD_ID_WIDTH = 16;

  localparam int IN_ADDR_W = 64;
  localparam int IN_TID_W  = 16;

  typedef enum logic [1:0] {
    OP_ADD           = 2'd0,
    OP_POP           = 2'd1,
    OP_REMOVE        = 2'd2,
    OP_REMOVE_THREAD = 2'd3
  } op_t;

  // per-cell control from the sequencer
  typedef struct packed {
    logic cmp;    // compare against the operation, seed the hit wave
    logic scan;   // advance the hit wave by one cell
    logic shift;  // take the right neighbor's entry
    logic wr;     // load the operation's entry
  } cell_ctl_t;

endpackage

[hdl/fwt_cell.sv]
module fwt_cell
  import fwt_pkg::*;
#(
  parameter int ADDRESS_WIDTH   = DEF_ADDRESS_WIDTH,
  parameter int THREAD_ID_WIDTH = DEF_THREAD_ID_WIDTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  cell_ctl_t                  ctl,
  input  logic                       occupied,
  input  op_t                        op_func,
  input  logic [ADDRESS_WIDTH-1:0]   op_addr,
  input  logic [THREAD_ID_WIDTH-1:0] op_tid,
  input  logic                       left_acc,
  input  logic [THREAD_ID_WIDTH-1:0] left_wk,
  input  logic [ADDRESS_WIDTH-1:0]   right_addr,
  input  logic [THREAD_ID_WIDTH-1:0] right_thr,
  output logic                       acc,
  output logic [THREAD_ID_WIDTH-1:0] wk,
  output logic [ADDRESS_WIDTH-1:0]   addr,
  output logic [THREAD_ID_WIDTH-1:0] thr
);

  logic                       hit_r, hit_nxt;
  logic                       acc_r, acc_nxt;
  logic [THREAD_ID_WIDTH-1:0] wk_r, wk_nxt;
  logic [ADDRESS_WIDTH-1:0]   addr_r, addr_nxt;
  logic [THREAD_ID_WIDTH-1:0] thr_r, thr_nxt;
  logic                       match;

  always_comb begin
    case (op_func)
      OP_ADD, OP_REMOVE_THREAD: match = (thr_r == op_tid);
      OP_POP:                   match = (addr_r == op_addr);
      OP_REMOVE:                match = (addr_r == op_addr) && (thr_r == op_tid);
      default:                  match = 1'b0;
    endcase
  end

  always_comb begin
    hit_nxt  = hit_r;
    acc_nxt  = acc_r;
    wk_nxt   = wk_r;
    addr_nxt = addr_r;
    thr_nxt  = thr_r;
    if (ctl.cmp) begin
      hit_nxt = occupied && match;
      acc_nxt = occupied && match;
      wk_nxt  = (occupied && match) ? thr_r : '0;
    end else if (ctl.scan) begin
      // running OR of hits from cell 0; wk carries the first hit's thread
      acc_nxt = left_acc | hit_r;
      wk_nxt  = left_acc ? left_wk : (hit_r ? thr_r : '0);
    end
    if (ctl.shift) begin
      addr_nxt = right_addr;
      thr_nxt  = right_thr;
    end else if (ctl.wr) begin
      addr_nxt = op_addr;
      thr_nxt  = op_tid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
      acc_r <= 1'b0;
    end else begin
      hit_r <= hit_nxt;
      acc_r <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wk_r   <= wk_nxt;
    addr_r <= addr_nxt;
    thr_r  <= thr_nxt;
  end

  assign acc  = acc_r;
  assign wk   = wk_r;
  assign addr = addr_r;
  assign thr  = thr_r;

endmodule

[hdl/futex_waiter_table.sv]
// Ordered table of futex waiters, oldest entry first.
// Input channel: in_func, in_wait_address, in_thread_id are taken at a rising
// edge with start high and busy low. Operations: add, pop oldest by address,
// remove (address, thread), remove thread.
// Result channel: out_ok and out_woken_thread are valid for the single cycle
// in which out_strobe is high; there is no backpressure.
// Each operation walks the row of cells in three phases: compare, hit wave
// (one cell per cycle, which gives the oldest match and the any-match flag
// at the last cell), and commit. out_strobe rises and busy drops in the same
// cycle, so a new operation is taken only after the last one has completed.
// A deletion shifts every younger entry one cell toward the head in the
// commit cycle.
// Reset (rst_n low, synchronous) empties the table and returns to idle;
// entry contents are not cleared, only the fill count.
module futex_waiter_table
  import fwt_pkg::*;
#(
  parameter int TABLE_DEPTH     = DEF_TABLE_DEPTH,
  parameter int ADDRESS_WIDTH   = DEF_ADDRESS_WIDTH,
  parameter int THREAD_ID_WIDTH = DEF_THREAD_ID_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           in_func,
  input  logic [IN_ADDR_W-1:0] in_wait_address,
  input  logic [IN_TID_W-1:0]  in_thread_id,
  output logic                 out_strobe,
  output logic                 out_ok,
  output logic [IN_TID_W-1:0]  out_woken_thread
);

  localparam int CW  = $clog2(TABLE_DEPTH + 1);
  localparam int SCW = $clog2(TABLE_DEPTH);
  localparam logic [SCW-1:0] SCAN_LAST = SCW'(TABLE_DEPTH - 2);
  localparam logic [CW-1:0]  FULL_CNT  = CW'(TABLE_DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_SCAN,
    ST_COMMIT
  } state_t;

  state_t                     state_r;
  logic [SCW-1:0]             scan_cnt_r;
  logic [CW-1:0]              count_r;
  logic                       out_strobe_r;
  logic                       out_ok_r;
  logic [IN_TID_W-1:0]        out_woken_r;

  op_t                        op_func_r;
  logic [ADDRESS_WIDTH-1:0]   op_addr_r;
  logic [THREAD_ID_WIDTH-1:0] op_tid_r;

  logic                       accept;
  logic                       any_hit;
  logic                       full;
  logic                       del_op;

  cell_ctl_t                  ctl      [TABLE_DEPTH];
  logic                       acc_o    [TABLE_DEPTH];
  logic [THREAD_ID_WIDTH-1:0] wk_o     [TABLE_DEPTH];
  logic [ADDRESS_WIDTH-1:0]   addr_o   [TABLE_DEPTH];
  logic [THREAD_ID_WIDTH-1:0] thr_o    [TABLE_DEPTH];

  assign accept  = start && !busy;
  assign busy    = (state_r != ST_IDLE);
  assign any_hit = acc_o[TABLE_DEPTH-1];
  assign full    = (count_r == FULL_CNT);
  assign del_op  = (op_func_r != OP_ADD);

  always_ff @(posedge clk) begin
    if (accept) begin
      op_func_r <= op_t'(in_func);
      op_addr_r <= in_wait_address[ADDRESS_WIDTH-1:0];
      op_tid_r  <= in_thread_id[THREAD_ID_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      scan_cnt_r   <= '0;
      count_r      <= '0;
      out_strobe_r <= 1'b0;
      out_ok_r     <= 1'b0;
      out_woken_r  <= '0;
    end else begin
      out_strobe_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            state_r <= ST_CMP;
          end
        end
        ST_CMP: begin
          scan_cnt_r <= '0;
          state_r    <= ST_SCAN;
        end
        ST_SCAN: begin
          scan_cnt_r <= scan_cnt_r + 1'b1;
          if (scan_cnt_r == SCAN_LAST) begin
            state_r <= ST_COMMIT;
          end
        end
        ST_COMMIT: begin
          state_r      <= ST_IDLE;
          out_strobe_r <= 1'b1;
          out_woken_r  <= '0;
          if (op_func_r == OP_ADD) begin
            // a thread already waiting counts as success
            out_ok_r <= any_hit || !full;
            if (!any_hit && !full) begin
              count_r <= count_r + 1'b1;
            end
          end else begin
            out_ok_r <= any_hit;
            if (any_hit) begin
              count_r <= count_r - 1'b1;
              if (op_func_r == OP_POP) begin
                out_woken_r <= IN_TID_W'(wk_o[TABLE_DEPTH-1]);
              end
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_strobe       = out_strobe_r;
  assign out_ok           = out_ok_r;
  assign out_woken_thread = out_woken_r;

  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    logic                       occ;
    logic                       l_acc;
    logic [THREAD_ID_WIDTH-1:0] l_wk;
    logic [ADDRESS_WIDTH-1:0]   r_addr;
    logic [THREAD_ID_WIDTH-1:0] r_thr;

    assign occ = (CW'(k) < count_r);

    assign ctl[k].cmp   = (state_r == ST_CMP);
    assign ctl[k].scan  = (state_r == ST_SCAN);
    // acc at or after the first hit marks the cells that close the gap
    assign ctl[k].shift = (state_r == ST_COMMIT) && del_op && any_hit && acc_o[k];
    assign ctl[k].wr    = (state_r == ST_COMMIT) && (op_func_r == OP_ADD) && !any_hit
                          && !full && (count_r == CW'(k));

    if (k == 0) begin : g_head
      assign l_acc = 1'b0;
      assign l_wk  = '0;
    end else begin : g_mid
      assign l_acc = acc_o[k-1];
      assign l_wk  = wk_o[k-1];
    end

    if (k == TABLE_DEPTH - 1) begin : g_tail
      assign r_addr = addr_o[k];
      assign r_thr  = thr_o[k];
    end else begin : g_body
      assign r_addr = addr_o[k+1];
      assign r_thr  = thr_o[k+1];
    end

    fwt_cell #(
      .ADDRESS_WIDTH  (ADDRESS_WIDTH),
      .THREAD_ID_WIDTH(THREAD_ID_WIDTH)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl[k]),
      .occupied  (occ),
      .op_func   (op_func_r),
      .op_addr   (op_addr_r),
      .op_tid    (op_tid_r),
      .left_acc  (l_acc),
      .left_wk   (l_wk),
      .right_addr(r_addr),
      .right_thr (r_thr),
      .acc       (acc_o[k]),
      .wk        (wk_o[k]),
      .addr      (addr_o[k]),
      .thr       (thr_o[k])
    );
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy && state_r == ST_CMP)
    else $error("accepted beat did not start an operation");

  a_commit_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_COMMIT |=> out_strobe && !busy)
    else $error("commit did not produce exactly one result beat");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("fill count beyond table depth");

  a_woken_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (!out_ok || op_func_r != OP_POP) |-> out_woken_thread == '0)
    else $error("woken thread set without a successful pop");

  a_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_COMMIT |=> $stable(count_r))
    else $error("fill count changed outside commit");

endmodule

[verif/futex_waiter_table_checker.sv]
`timescale 1ns / 100ps

module futex_waiter_table_checker
  import fwt_pkg::*;
#(
  parameter int TABLE_DEPTH     = DEF_TABLE_DEPTH,
  parameter int ADDRESS_WIDTH   = DEF_ADDRESS_WIDTH,
  parameter int THREAD_ID_WIDTH = DEF_THREAD_ID_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  logic [1:0]           in_func,
  input  logic [IN_ADDR_W-1:0] in_wait_address,
  input  logic [IN_TID_W-1:0]  in_thread_id,
  input  logic                 out_strobe,
  input  logic                 out_ok,
  input  logic [IN_TID_W-1:0]  out_woken_thread,
  output int                   mismatches,
  output int                   replies_due
);

  localparam logic [IN_ADDR_W-1:0] ADDR_MASK =
    (ADDRESS_WIDTH >= IN_ADDR_W) ? '1 : ((64'd1 << ADDRESS_WIDTH) - 64'd1);
  localparam logic [IN_TID_W-1:0] TID_MASK =
    (THREAD_ID_WIDTH >= IN_TID_W) ? '1 : ((16'd1 << THREAD_ID_WIDTH) - 16'd1);

  typedef struct {
    bit              ok;
    bit [IN_TID_W-1:0] woken;
  } waiter_reply_t;

  // mirror of the waiter table, oldest at index 0
  bit [IN_ADDR_W-1:0] waiter_addr[TABLE_DEPTH];
  bit [IN_TID_W-1:0]  waiter_tid[TABLE_DEPTH];
  int                 waiter_count;

  waiter_reply_t pending_replies[$];

  initial begin
    mismatches   = 0;
    replies_due  = 0;
    waiter_count = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns: waiter table mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // delete one entry and slide the younger ones toward the head
  task automatic close_gap(input int pos);
    for (int k = pos; k + 1 < waiter_count; k++) begin
      waiter_addr[k] = waiter_addr[k + 1];
      waiter_tid[k]  = waiter_tid[k + 1];
    end
    waiter_count--;
  endtask

  task automatic model_waiter_op(input op_t op, input bit [IN_ADDR_W-1:0] addr_in,
                                 input bit [IN_TID_W-1:0] tid_in,
                                 output waiter_reply_t reply);
    bit [IN_ADDR_W-1:0] addr;
    bit [IN_TID_W-1:0]  tid;
    bit                 present;
    int                 i;
    addr        = addr_in & ADDR_MASK;
    tid         = tid_in & TID_MASK;
    reply.ok    = 1'b0;
    reply.woken = '0;
    case (op)
      OP_ADD: begin
        present = 1'b0;
        for (i = 0; i < waiter_count; i++)
          if (waiter_tid[i] == tid) present = 1'b1;
        if (present) begin
          reply.ok = 1'b1;
        end else if (waiter_count < TABLE_DEPTH) begin
          waiter_addr[waiter_count] = addr;
          waiter_tid[waiter_count]  = tid;
          waiter_count++;
          reply.ok = 1'b1;
        end
      end
      OP_POP: begin
        for (i = 0; i < waiter_count; i++) begin
          if (waiter_addr[i] == addr) begin
            reply.woken = waiter_tid[i];
            reply.ok    = 1'b1;
            close_gap(i);
            break;
          end
        end
      end
      OP_REMOVE: begin
        for (i = 0; i < waiter_count; i++) begin
          if (waiter_addr[i] == addr && waiter_tid[i] == tid) begin
            reply.ok = 1'b1;
            close_gap(i);
            break;
          end
        end
      end
      default: begin
        i = 0;
        while (i < waiter_count) begin
          if (waiter_tid[i] == tid) begin
            close_gap(i);
            reply.ok = 1'b1;
          end else begin
            i++;
          end
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    waiter_reply_t got_exp;
    waiter_reply_t new_exp;
    if (!rst_n) begin
      pending_replies.delete();
      waiter_count = 0;
    end else begin
      // the result of the previous beat may share this edge with a new beat
      if (out_strobe) begin
        if (pending_replies.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected (ok=%b woken=%h)",
                                    out_ok, out_woken_thread));
        end else begin
          got_exp = pending_replies.pop_front();
          if (out_ok !== got_exp.ok)
            report_mismatch($sformatf("ok %b, expected %b", out_ok, got_exp.ok));
          if (out_woken_thread !== got_exp.woken)
            report_mismatch($sformatf("woken_thread %h, expected %h",
                                      out_woken_thread, got_exp.woken));
        end
      end
      if (start && !busy) begin
        model_waiter_op(op_t'(in_func), in_wait_address, in_thread_id, new_exp);
        pending_replies.push_back(new_exp);
      end
    end
    replies_due = pending_replies.size();
  end

endmodule

[verif/tb_futex_waiter_table.sv]
`timescale 1ns / 100ps

module tb_futex_waiter_table;
  import fwt_pkg::*;

  localparam int DEPTH       = DEF_TABLE_DEPTH;
  localparam int RANDOM_OPS  = 1000;
  localparam int STALL_LIMIT = 4000;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [1:0]           in_func;
  logic [IN_ADDR_W-1:0] in_wait_address;
  logic [IN_TID_W-1:0]  in_thread_id;
  logic                 out_strobe;
  logic                 out_ok;
  logic [IN_TID_W-1:0]  out_woken_thread;

  int mismatches;
  int replies_due;
  int beats_sent;
  int stall_cycles;
  bit quiet_sender;

  logic [IN_ADDR_W-1:0] addr_pool[8];
  logic [IN_TID_W-1:0]  tid_pool[96];
  logic [IN_TID_W-1:0]  burst_base;

  futex_waiter_table u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_func         (in_func),
    .in_wait_address (in_wait_address),
    .in_thread_id    (in_thread_id),
    .out_strobe      (out_strobe),
    .out_ok          (out_ok),
    .out_woken_thread(out_woken_thread)
  );

  futex_waiter_table_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_func         (in_func),
    .in_wait_address (in_wait_address),
    .in_thread_id    (in_thread_id),
    .out_strobe      (out_strobe),
    .out_ok          (out_ok),
    .out_woken_thread(out_woken_thread),
    .mismatches      (mismatches),
    .replies_due     (replies_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [IN_ADDR_W-1:0] rand_addr();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [IN_ADDR_W-1:0] pick_addr();
    if ($urandom_range(0, 99) < 85) return addr_pool[$urandom_range(0, 7)];
    return rand_addr();
  endfunction

  function automatic logic [IN_TID_W-1:0] pick_tid();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return tid_pool[$urandom_range(0, 95)];
    if (r < 85) return burst_base + IN_TID_W'($urandom_range(0, DEPTH + 5));
    return IN_TID_W'($urandom);
  endfunction

  // called at a falling edge; returns at a falling edge once the beat is taken
  task automatic send_op(input op_t op, input logic [IN_ADDR_W-1:0] addr,
                         input logic [IN_TID_W-1:0] tid);
    start           <= 1'b1;
    in_func         <= op;
    in_wait_address <= addr;
    in_thread_id    <= tid;
    // busy only moves at a rising edge, so its value here holds for the next one
    while (busy) @(negedge clk);
    @(negedge clk);
    beats_sent++;
    if (!quiet_sender && $urandom_range(0, 99) < 28) begin
      start <= 1'b0;
      // mostly short gaps, some long enough to cover every phase of the walk
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(20, DEPTH + 16)) @(negedge clk);
      else repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  task automatic random_op(input int add_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < add_pct) send_op(OP_ADD, pick_addr(), pick_tid());
    else begin
      r = $urandom_range(0, 2);
      if (r == 0) send_op(OP_POP, pick_addr(), IN_TID_W'($urandom));
      else if (r == 1) send_op(OP_REMOVE, pick_addr(), pick_tid());
      else send_op(OP_REMOVE_THREAD, rand_addr(), pick_tid());
    end
  endtask

  // stall watchdog: nothing accepted on either channel for too long
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_cycles <= 0;
    end else if ((start && !busy) || out_strobe) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int kind;
    int random_start;
    rst_n           = 1'b0;
    start           = 1'b0;
    in_func         = OP_ADD;
    in_wait_address = '0;
    in_thread_id    = '0;
    beats_sent      = 0;
    quiet_sender    = 1'b0;
    burst_base      = '0;
    foreach (addr_pool[i]) addr_pool[i] = rand_addr();
    foreach (tid_pool[i]) tid_pool[i] = IN_TID_W'($urandom);

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // extremes, duplicates, misses and the order of matches
    send_op(OP_ADD, '0, '0);
    send_op(OP_ADD, '1, '1);
    send_op(OP_ADD, {32{2'b01}}, {8{2'b10}});
    send_op(OP_ADD, {32{2'b10}}, {8{2'b01}});
    send_op(OP_ADD, 64'h1234, '0);              // thread already waiting
    send_op(OP_POP, '1, '0);
    send_op(OP_POP, '1, '1);                    // no waiter left there
    send_op(OP_REMOVE, '0, '1);                 // address hit, thread miss
    send_op(OP_REMOVE, '0, '0);
    send_op(OP_REMOVE_THREAD, '1, {8{2'b10}});
    send_op(OP_REMOVE_THREAD, '0, {8{2'b10}});
    send_op(OP_POP, '0, '1);
    send_op(OP_ADD, {32{2'b10}}, 16'h0001);
    send_op(OP_POP, {32{2'b10}}, '0);           // oldest of two on one address
    send_op(OP_POP, {32{2'b10}}, '0);
    send_op(OP_POP, {32{2'b10}}, '0);           // table empty
    send_op(OP_REMOVE_THREAD, '0, '0);
    send_op(OP_REMOVE, '1, '1);

    random_start = beats_sent;
    while (beats_sent - random_start < RANDOM_OPS) begin
      quiet_sender = (beats_sent - random_start >= 400) &&
                     (beats_sent - random_start < 600);
      kind = $urandom_range(0, 9);
      if (kind < 2) begin
        // fill burst with fresh threads: runs the table into full
        burst_base = IN_TID_W'($urandom);
        for (int k = 0; k < DEPTH + 6; k++)
          send_op(OP_ADD, pick_addr(), burst_base + IN_TID_W'(k));
      end else if (kind < 4) begin
        repeat (40) random_op(15);
      end else if (kind == 4) begin
        foreach (addr_pool[i]) addr_pool[i] = rand_addr();
        repeat (20) random_op(50);
      end else begin
        repeat (30) random_op(55);
      end
    end

    start <= 1'b0;
    @(negedge clk);
    while (replies_due != 0) @(negedge clk);
    repeat (DEPTH + 8) @(negedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
